### rtl/fmc_pkg.sv
// shared types, constants and colour band function for the fft magnitude colormap unit
package fmc_pkg;

   localparam logic [31:0] FULL_SCALE_DEFAULT = 32'd65535;

   // index scale 255 squared
   localparam int unsigned IDX_SCALE_SQ = 65025;

   localparam int unsigned IDX_W = 8;
   localparam int unsigned THR_W = 80;

   typedef enum logic [0:0] {
      CMAP_JET     = 1'b0,
      CMAP_THERMAL = 1'b1
   } cmap_mode_type;

   // band centres and half widths
   localparam logic [8:0] JET_RED_C       = 9'd192;
   localparam logic [8:0] JET_GREEN_C     = 9'd128;
   localparam logic [8:0] JET_BLUE_C      = 9'd64;
   localparam logic [7:0] JET_HALF_W      = 8'd96;
   localparam logic [8:0] THERM_RED_C     = 9'd256;
   localparam logic [8:0] THERM_GREEN_C   = 9'd128;
   localparam logic [8:0] THERM_BLUE_C    = 9'd0;
   localparam logic [7:0] THERM_HALF_W    = 8'd128;

   typedef struct packed {
      logic signed [31:0] real_part;
      logic signed [31:0] imag_part;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] color_index;
   } rsp_type;

   // clamp(half_w - |idx - centre|): 0 at or below 0, x*255/64 up to 64, 255 above
   function automatic logic [7:0] band_level(input logic [7:0] idx,
                                             input logic [8:0] centre,
                                             input logic [7:0] half_w);
      logic signed [9:0] diff;
      logic [8:0]        dist_abs;
      logic signed [9:0] x;
      logic [13:0]       prod;
      logic [7:0]        level;
      diff     = signed'({2'b00, idx}) - signed'({1'b0, centre});
      dist_abs = diff[9] ? 9'(-diff) : diff[8:0];
      x        = signed'({2'b00, half_w}) - signed'({1'b0, dist_abs});
      prod     = 14'(x[6:0]) * 14'd255;
      if (x <= 10'sd0) begin
         level = 8'd0;
      end else if (x <= 10'sd64) begin
         level = prod[13:6];
      end else begin
         level = 8'd255;
      end
      return level;
   endfunction

endpackage

### rtl/fft_magnitude_colormap_unit.sv
// top level: fft bin magnitude to colormap index and rgb pixel, deep pipeline
//
// Usage notes
// - req channel: one complex bin (signed real and imaginary parts) per transaction,
//   taken at a clock edge with req_valid high and req_stall low.
// - rsp channel: one pixel (red, green, blue, color_index) per bin, in order,
//   handed over at an edge with rsp_valid high and rsp_stall low.
// - csr channel: one-bit colormap mode (0 jet, 1 thermal), csr_ready is always
//   high; write it only while no transaction is in flight.
// - Pipeline: 14 register stages: magnitude, squares, sum, two shift-add
//   stages for the 65025 scaling, eight binary search stages against a
//   constant threshold table, colour stage.
// - Throughput: one bin per clock, sustained while rsp_stall is low.
// - rsp_stall holds the output and fills the pipeline's empty stages first;
//   req_stall rises only once every stage holds a bin.
// - Reset (synchronous) empties the pipeline and selects the jet map.
module fft_magnitude_colormap_unit #(
   parameter logic [31:0] FULL_SCALE = fmc_pkg::FULL_SCALE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fmc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fmc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata
);
   import fmc_pkg::*;

   localparam int unsigned NUM_STAGES = 14;
   localparam int unsigned SRCH_FIRST = 5;
   localparam int unsigned SRCH_STEPS = IDX_W;
   localparam int unsigned TBL_DEPTH  = 2 ** IDX_W;
   localparam int unsigned KFS_W      = 40;

   cmap_mode_type          mode_ff;
   logic [NUM_STAGES-1:0]  valid_ff;
   logic [NUM_STAGES-1:0]  valid_in;
   logic [NUM_STAGES:0]    stage_en;

   logic [31:0]            mag_re_ff, mag_im_ff, mag_re_in, mag_im_in;
   logic [63:0]            sq_re_ff, sq_im_ff, sq_re_in, sq_im_in;
   logic [63:0]            sumsq_ff, sumsq_in;
   logic [63:0]            sum_dly_ff;
   logic [72:0]            part_ff, part_in;
   logic [THR_W-1:0]       rhs_ff [SRCH_STEPS];
   logic [IDX_W-1:0]       k_ff   [SRCH_STEPS];
   rsp_type                rsp_ff, rsp_in;
   logic [THR_W-1:0]       thr_table [TBL_DEPTH];

   // threshold for index k is (k * full scale)^2, fixed at elaboration
   for (genvar t = 0; t < TBL_DEPTH; t++) begin : g_thr
      localparam logic [KFS_W-1:0] KFS = KFS_W'(t) * KFS_W'(FULL_SCALE);
      assign thr_table[t] = THR_W'(KFS) * THR_W'(KFS);
   end

   // stage enables: a stage moves when empty or when the one after it moves
   always_comb begin
      stage_en[NUM_STAGES] = !rsp_stall;
      for (int s = NUM_STAGES - 1; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
      valid_in = (stage_en[NUM_STAGES-1:0] & {valid_ff[NUM_STAGES-2:0], req_valid})
               | (~stage_en[NUM_STAGES-1:0] & valid_ff);
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mode_ff  <= CMAP_JET;
      end else begin
         valid_ff <= valid_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= cmap_mode_type'(csr_wdata);
         end
      end
   end

   // front stages: magnitudes, squares, sum, scaling by 65025 = 2^16 - (2^9 - 1)
   always_comb begin
      mag_re_in = req_data.real_part[31] ? (~req_data.real_part + 32'd1)
                                         : req_data.real_part;
      mag_im_in = req_data.imag_part[31] ? (~req_data.imag_part + 32'd1)
                                         : req_data.imag_part;
      sq_re_in  = 64'(mag_re_ff) * 64'(mag_re_ff);
      sq_im_in  = 64'(mag_im_ff) * 64'(mag_im_ff);
      sumsq_in  = sq_re_ff + sq_im_ff;
      part_in   = {sumsq_ff, 9'd0} - 73'(sumsq_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         mag_re_ff <= mag_re_in;
         mag_im_ff <= mag_im_in;
      end
      if (stage_en[1]) begin
         sq_re_ff <= sq_re_in;
         sq_im_ff <= sq_im_in;
      end
      if (stage_en[2]) begin
         sumsq_ff <= sumsq_in;
      end
      if (stage_en[3]) begin
         sum_dly_ff <= sumsq_ff;
         part_ff    <= part_in;
      end
      if (stage_en[4]) begin
         rhs_ff[0] <= {sum_dly_ff, 16'd0} - THR_W'(part_ff);
      end
   end

   // binary search, one index bit per stage, msb first
   for (genvar j = 0; j < SRCH_STEPS; j++) begin : g_srch
      localparam logic [IDX_W-1:0] BIT = IDX_W'(1 << (SRCH_STEPS - 1 - j));
      logic [IDX_W-1:0] k_prev;
      logic [IDX_W-1:0] cand;
      logic [IDX_W-1:0] k_in;

      if (j == 0) begin : g_first
         assign k_prev = '0;
      end else begin : g_next
         assign k_prev = k_ff[j-1];
      end

      assign cand = k_prev | BIT;
      assign k_in = (thr_table[cand] <= rhs_ff[j]) ? cand : k_prev;

      always_ff @(posedge clock) begin
         if (stage_en[SRCH_FIRST+j]) begin
            k_ff[j] <= k_in;
         end
      end

      if (j < SRCH_STEPS - 1) begin : g_rhs
         always_ff @(posedge clock) begin
            if (stage_en[SRCH_FIRST+j]) begin
               rhs_ff[j+1] <= rhs_ff[j];
            end
         end
      end
   end

   // colour stage
   always_comb begin
      rsp_in.color_index = k_ff[SRCH_STEPS-1];
      case (mode_ff)
         CMAP_THERMAL: begin
            rsp_in.red   = band_level(k_ff[SRCH_STEPS-1], THERM_RED_C, THERM_HALF_W);
            rsp_in.green = band_level(k_ff[SRCH_STEPS-1], THERM_GREEN_C, THERM_HALF_W);
            rsp_in.blue  = band_level(k_ff[SRCH_STEPS-1], THERM_BLUE_C, THERM_HALF_W);
         end
         default: begin
            rsp_in.red   = band_level(k_ff[SRCH_STEPS-1], JET_RED_C, JET_HALF_W);
            rsp_in.green = band_level(k_ff[SRCH_STEPS-1], JET_GREEN_C, JET_HALF_W);
            rsp_in.blue  = band_level(k_ff[SRCH_STEPS-1], JET_BLUE_C, JET_HALF_W);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[NUM_STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### rtl/fmc_checker.sv
// port-level checks for the fft magnitude colormap unit, bound to the top level
module fmc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input fmc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fmc_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic             csr_wdata
);
   import fmc_pkg::*;

   // a held result transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // input back-pressure only when the output itself is held
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || !rsp_stall |-> !req_stall)
      else $error("req_stall without a held rsp transaction");

   // index zero lies outside both red bands
   a_zero_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.color_index == 8'd0) |-> rsp_data.red == 8'd0)
      else $error("red non-zero at colour index zero");

endmodule

bind fft_magnitude_colormap_unit fmc_checker u_fmc_checker (.*);
